FILE: rtl/tisf_pkg.sv
// ----------------------------------------------------------------------------
// tisf_pkg
// Shared types and Telnet codes for the IAC stream filter.
// ----------------------------------------------------------------------------
package tisf_pkg;

   localparam logic [7:0] TN_IAC  = 8'hFF;
   localparam logic [7:0] TN_DONT = 8'hFE;
   localparam logic [7:0] TN_DO   = 8'hFD;
   localparam logic [7:0] TN_WONT = 8'hFC;
   localparam logic [7:0] TN_WILL = 8'hFB;
   localparam logic [7:0] TN_SB   = 8'hFA;
   localparam logic [7:0] TN_SE   = 8'hF0;

   // last beat index of a refusal burst (IAC, cmd, option)
   localparam logic [1:0] BEAT_LAST = 2'd2;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_IAC    = 3'd1,
      MODE_WILL   = 3'd2,
      MODE_WONT   = 3'd3,
      MODE_DO     = 3'd4,
      MODE_DONT   = 3'd5,
      MODE_SUB    = 3'd6,
      MODE_SUBIAC = 3'd7
   } tisf_mode_type;

   // what one received byte produces
   typedef struct packed {
      logic       emit;    // at least one result
      logic       refuse;  // three-beat refusal toward the network
      logic [7:0] cmd;     // DONT or WONT for a refusal
      logic [7:0] data;    // terminal byte, or option byte of a refusal
   } tisf_emit_type;

endpackage

FILE: rtl/tisf_decode.sv
// ----------------------------------------------------------------------------
// tisf_decode
// Telnet parser step: next mode and emitted results for one byte.
// ----------------------------------------------------------------------------
module tisf_decode (
   input  tisf_pkg::tisf_mode_type mode,
   input  logic [7:0]              rx_byte,
   input  logic                    link_up,
   output tisf_pkg::tisf_mode_type mode_next,
   output tisf_pkg::tisf_emit_type emit
);
   import tisf_pkg::*;

   // next state
   always_comb begin
      mode_next = mode;
      case (mode)
         MODE_NORMAL: begin
            if (rx_byte == TN_IAC) mode_next = MODE_IAC;
         end
         MODE_IAC: begin
            case (rx_byte)
               TN_WILL: mode_next = MODE_WILL;
               TN_WONT: mode_next = MODE_WONT;
               TN_DO:   mode_next = MODE_DO;
               TN_DONT: mode_next = MODE_DONT;
               TN_SB:   mode_next = MODE_SUB;
               default: mode_next = MODE_NORMAL;
            endcase
         end
         MODE_WILL, MODE_WONT, MODE_DO, MODE_DONT: begin
            mode_next = MODE_NORMAL;
         end
         MODE_SUB: begin
            if (rx_byte == TN_IAC) mode_next = MODE_SUBIAC;
         end
         MODE_SUBIAC: begin
            if (rx_byte == TN_SE)       mode_next = MODE_NORMAL;
            else if (rx_byte != TN_IAC) mode_next = MODE_SUB;
         end
         default: mode_next = MODE_NORMAL;
      endcase
   end

   // outputs
   always_comb begin
      emit.emit   = 1'b0;
      emit.refuse = 1'b0;
      emit.cmd    = (mode == MODE_WILL) ? TN_DONT : TN_WONT;
      emit.data   = rx_byte;
      case (mode)
         MODE_NORMAL: emit.emit = (rx_byte != TN_IAC);
         MODE_IAC:    emit.emit = (rx_byte == TN_IAC);
         MODE_WILL, MODE_DO: begin
            emit.emit   = link_up;
            emit.refuse = link_up;
         end
         default: emit.emit = 1'b0;
      endcase
   end

endmodule

FILE: rtl/telnet_iac_stream_filter.sv
// ----------------------------------------------------------------------------
// telnet_iac_stream_filter
// Strips Telnet commands from a received byte stream and refuses all option requests while the link is up.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser       | tlast
//  req_    | in  | [7:0] rx_byte, [8] link_up     | -           | -
//  rsp_    | out | [7:0] out_byte                 | to_network  | last_of_run
//
//  One request is taken per cycle unless the result register is busy or stalled;
//  each passes the input register, then the result register. A plain
//  byte gives one result, an option request (WILL/DO while link is up)
//  gives a three-beat refusal, held until its last beat is taken.
//  Requests giving no result pass through the decoder without using a beat.
//  Reset (synchronous) empties both registers and returns the parser to
//  normal data mode. rsp_tready low stalls the result register, and the
//  input register fills behind it before req_tready drops.
// ----------------------------------------------------------------------------
module telnet_iac_stream_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [8] link_up, [15:9] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] to_network
   output logic        rsp_tlast    // last_of_run
);
   import tisf_pkg::*;

   // input register
   logic          in_vld_ff, in_vld_in;
   logic [7:0]    in_byte_ff;
   logic          in_link_ff;

   // parser state
   tisf_mode_type mode_ff, mode_in, mode_next;
   tisf_emit_type emit;

   // result register
   logic          out_vld_ff, out_vld_in;
   logic [1:0]    beat_ff, beat_in;
   logic          burst_ff;
   logic [7:0]    cmd_ff;
   logic [7:0]    data_ff;

   logic          req_accept;
   logic          rsp_accept;
   logic          s2_free;
   logic          s1_move;

   tisf_decode u_decode (
      .mode      (mode_ff),
      .rx_byte   (in_byte_ff),
      .link_up   (in_link_ff),
      .mode_next (mode_next),
      .emit      (emit)
   );

   // handshakes
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign s2_free    = !out_vld_ff || (rsp_accept && rsp_tlast);
   assign s1_move    = in_vld_ff && s2_free;
   assign req_tready = !in_vld_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   // next values of control state
   always_comb begin
      in_vld_in  = in_vld_ff;
      mode_in    = mode_ff;
      out_vld_in = out_vld_ff;
      beat_in    = beat_ff;
      if (s1_move) begin
         in_vld_in = 1'b0;
         mode_in   = mode_next;
      end
      if (req_accept) in_vld_in = 1'b1;
      if (s1_move) begin
         out_vld_in = emit.emit;
         beat_in    = '0;
      end else if (rsp_accept) begin
         if (rsp_tlast) out_vld_in = 1'b0;
         else           beat_in    = beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mode_ff    <= MODE_NORMAL;
         out_vld_ff <= 1'b0;
         beat_ff    <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         mode_ff    <= mode_in;
         out_vld_ff <= out_vld_in;
         beat_ff    <= beat_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata[7:0];
         in_link_ff <= req_tdata[8];
      end
      if (s1_move) begin
         burst_ff <= emit.refuse;
         cmd_ff   <= emit.cmd;
         data_ff  <= emit.data;
      end
   end

   // result beat select: refusal is IAC, cmd, option
   always_comb begin
      rsp_tdata = data_ff;
      if (burst_ff) begin
         case (beat_ff)
            2'd0:    rsp_tdata = TN_IAC;
            2'd1:    rsp_tdata = cmd_ff;
            default: rsp_tdata = data_ff;
         endcase
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = burst_ff;
   assign rsp_tlast  = !burst_ff || (beat_ff == BEAT_LAST);

`ifndef ASSERT_OFF
   // single-beat results never advance the beat counter
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !burst_ff |-> beat_ff == 2'd0)
      else $error("beat counter moved on a single result");

   // beat counter stays within a refusal burst
   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> beat_ff != 2'd3)
      else $error("beat counter past refusal burst");

   // refusal burst opens with IAC
   a_refuse_iac: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && burst_ff && beat_ff == 2'd0 |-> rsp_tdata == TN_IAC)
      else $error("refusal burst not led by IAC");

   // last beat taken with nothing behind it empties the result register
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && rsp_tlast && !in_vld_ff |=> !rsp_tvalid)
      else $error("result register did not drain");

   // a non-final beat taken keeps the burst going
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !rsp_tlast |=> rsp_tvalid && beat_ff == $past(beat_ff) + 2'd1)
      else $error("refusal burst broken");
`endif

endmodule
